/* hdl/sacache_pkg.sv */
// ----------------------------------------------------------------------------
// Set-associative cache directory: shared package
// Types, register indexes and helpers used by the cache directory modules.
// ----------------------------------------------------------------------------
package sacache_pkg;

  // Stamp and statistics counter widths.
  localparam int STAMP_W = 64;
  localparam int CNT_W   = 32;

  // Configuration register indexes.
  localparam logic [7:0] REG_FIFO_POLICY = 8'd0;
  localparam logic [7:0] REG_WAYS_IN_USE = 8'd1;
  localparam logic [7:0] REG_OFFSET_BITS = 8'd2;
  localparam logic [7:0] REG_SET_BITS    = 8'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic step;   // an entry is presented this cycle
    logic first;  // the entry is way 0 of the set
  } scan_ctl_t;

  // Status from the compare unit back to the sequencer.
  typedef struct packed {
    logic decided; // entry is invalid or matches: search ends here
    logic hit;     // entry is valid and its tag matches
  } scan_sts_t;

  // Saturating increment of a statistics counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
    logic [CNT_W-1:0] r;
    r = v;
    if (en && (v != {CNT_W{1'b1}})) begin
      r = v + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

/* hdl/sacache_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sacache_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/sacache_scan.sv */
// ----------------------------------------------------------------------------
// Cache directory compare unit
// Checks one directory entry per step against the lookup tag and keeps the
// oldest stamp seen so far in the set for victim selection.
// ----------------------------------------------------------------------------
module sacache_scan import sacache_pkg::*; #(
  parameter int TAG_W = 48,
  parameter int WAY_W = 3
) (
  input  logic               clk,
  input  scan_ctl_t          ctl,
  input  logic               ent_valid,
  input  logic [TAG_W-1:0]   ent_tag,
  input  logic [STAMP_W-1:0] ent_stamp,
  input  logic [TAG_W-1:0]   key_tag,
  input  logic [WAY_W-1:0]   cur_way,
  output scan_sts_t          sts,
  output logic [WAY_W-1:0]   pick_way
);

  logic [STAMP_W-1:0] best_stamp;
  logic [WAY_W-1:0]   best_way;
  logic               match;
  logic               cur_less;

  // Tag compare and stamp compare; ties keep the lower way.
  always_comb begin
    match       = ent_valid && (ent_tag == key_tag);
    cur_less    = ctl.first || (ent_stamp < best_stamp);
    sts.decided = !ent_valid || match;
    sts.hit     = match;
    pick_way    = cur_less ? cur_way : best_way;
  end

  // Running minimum over the valid, non-matching ways.
  always_ff @(posedge clk) begin
    if (ctl.step && !sts.decided && cur_less) begin
      best_stamp <= ent_stamp;
      best_way   <= cur_way;
    end
  end

endmodule

/* hdl/set_assoc_cache_lookup_lru_fifo_core.sv */
// ----------------------------------------------------------------------------
// Set-associative cache directory with LRU or FIFO replacement
// Looks up one memory access at a time, fills, refreshes or replaces a way,
// and reports the way together with saturating access statistics.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake                | Beat contents
//   --------+--------------------------+----------------------------------------
//   req     | req_valid / req_stall    | mode, address
//   rsp     | rsp_valid / rsp_stall    | hit, way, read/write/hit/miss_count
//   cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// An access goes from accept through the scan to the result register: the
// single RAM read port delivers one entry per cycle to the shared compare
// unit, then the write-back follows.
// After reset a clearing pass writes all MAX_SETS * MAX_WAYS entries, one
// per cycle; requests stall meanwhile.
// A stalled result holds the write-back until the response beat is taken;
// the next request may be accepted while a result waits.
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup_lru_fifo_core import sacache_pkg::*; #(
  parameter int MAX_SETS   = 1024,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  mode,
  input  logic [ADDR_WIDTH-1:0] address,
  // response channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  hit,
  output logic [2:0]            way,
  output logic [CNT_W-1:0]      read_count,
  output logic [CNT_W-1:0]      write_count,
  output logic [CNT_W-1:0]      hit_count,
  output logic [CNT_W-1:0]      miss_count,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_index,
  input  logic [3:0]            cfg_data
);

  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SET_LIM = $clog2(MAX_SETS + 1) - 1;
  localparam int DEPTH   = MAX_SETS * MAX_WAYS;
  localparam int ENT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LINE_W  = 1 + ADDR_WIDTH + STAMP_W;

  // Configuration registers.
  logic       fifo_policy;
  logic [3:0] ways_in_use;
  logic [3:0] offset_bits;
  logic [3:0] set_bits;

  // Sequencer and item registers.
  state_t              state, state_next;
  logic [ENT_W-1:0]    clr_addr;
  logic [ENT_W-1:0]    base_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [WCNT_W-1:0]   ways_q;
  logic                write_q;
  logic [WCNT_W-1:0]   rd_way;
  logic                cmp_pend;
  logic [WAY_W-1:0]    cmp_way;
  logic                hit_q;
  logic [WAY_W-1:0]    chosen_q;
  logic [STAMP_W-1:0]  stamp;

  // Decode of the incoming access.
  logic [5:0]            ways_w;
  logic [4:0]            sb_eff;
  logic [ADDR_WIDTH-1:0] shifted;
  logic [SET_W:0]        set_mask;
  logic [SET_W-1:0]      set_idx;
  logic [ADDR_WIDTH-1:0] tag_in;

  // RAM and compare unit signals.
  logic              ram_we;
  logic [ENT_W-1:0]  ram_waddr;
  logic [LINE_W-1:0] ram_wdata;
  logic [ENT_W-1:0]  ram_raddr;
  logic [LINE_W-1:0] ram_rdata;
  scan_ctl_t         scan_ctl;
  scan_sts_t         scan_sts;
  logic [WAY_W-1:0]  pick_way;

  logic req_take;
  logic issue;
  logic scan_done;
  logic upd_go;
  logic line_wr;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_policy <= 1'b0;
      ways_in_use <= 4'd1;
      offset_bits <= 4'd6;
      set_bits    <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIFO_POLICY: fifo_policy <= cfg_data[0];
        REG_WAYS_IN_USE: ways_in_use <= cfg_data;
        REG_OFFSET_BITS: offset_bits <= cfg_data;
        REG_SET_BITS:    set_bits    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Split the address into set index and tag under the clamped geometry.
  always_comb begin
    ways_w = {2'b00, ways_in_use};
    if (ways_w == 6'd0) begin
      ways_w = 6'd1;
    end else if (ways_w > 6'(MAX_WAYS)) begin
      ways_w = 6'(MAX_WAYS);
    end
    sb_eff   = ({1'b0, set_bits} > 5'(SET_LIM)) ? 5'(SET_LIM) : {1'b0, set_bits};
    shifted  = address >> offset_bits;
    set_mask = ((SET_W + 1)'(1) << sb_eff) - (SET_W + 1)'(1);
    set_idx  = shifted[SET_W-1:0] & set_mask[SET_W-1:0];
    tag_in   = address >> ({2'b00, offset_bits} + {1'b0, sb_eff});
  end

  // Scan control: one read issued and one entry compared per cycle.
  always_comb begin
    issue          = (rd_way < ways_q);
    scan_ctl.step  = (state == ST_SCAN) && cmp_pend;
    scan_ctl.first = (cmp_way == '0);
    scan_done      = scan_ctl.step &&
                     (scan_sts.decided || (cmp_way == WAY_W'(ways_q - WCNT_W'(1))));
    upd_go         = (state == ST_UPDATE) && (!rsp_valid || !rsp_stall);
    line_wr        = !hit_q || !fifo_policy;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == ENT_W'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (req_take) state_next = ST_SCAN;
      ST_SCAN:   if (scan_done) state_next = ST_UPDATE;
      ST_UPDATE: if (upd_go) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      cmp_pend <= 1'b0;
      rd_way   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ENT_W'(1);
      end
      if (req_take) begin
        rd_way   <= '0;
        cmp_pend <= 1'b0;
      end else if (state == ST_SCAN) begin
        if (issue) begin
          rd_way <= rd_way + WCNT_W'(1);
        end
        cmp_pend <= issue;
      end
    end
  end

  // Item payload registers.
  always_ff @(posedge clk) begin
    if (req_take) begin
      base_q  <= ENT_W'(set_idx) * ENT_W'(MAX_WAYS);
      tag_q   <= tag_in;
      ways_q  <= WCNT_W'(ways_w);
      write_q <= mode;
    end
    if ((state == ST_SCAN) && issue) begin
      cmp_way <= rd_way[WAY_W-1:0];
    end
    if (scan_done) begin
      hit_q    <= scan_sts.hit;
      chosen_q <= scan_sts.decided ? cmp_way : pick_way;
    end
  end

  // Write-back, stamp counter, statistics and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp       <= STAMP_W'(1);
      rsp_valid   <= 1'b0;
      read_count  <= '0;
      write_count <= '0;
      hit_count   <= '0;
      miss_count  <= '0;
    end else begin
      if (upd_go) begin
        rsp_valid   <= 1'b1;
        read_count  <= sat_inc(read_count, !hit_q);
        write_count <= sat_inc(write_count, write_q);
        hit_count   <= sat_inc(hit_count, hit_q);
        miss_count  <= sat_inc(miss_count, !hit_q);
        if (line_wr) begin
          stamp <= stamp + STAMP_W'(1);
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      hit <= hit_q;
      way <= 3'(chosen_q);
    end
  end

  // Directory RAM ports.
  always_comb begin
    ram_raddr = base_q + ENT_W'(rd_way[WAY_W-1:0]);
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_go && line_wr;
      ram_waddr = base_q + ENT_W'(chosen_q);
      ram_wdata = {1'b1, tag_q, stamp};
    end
  end

  sacache_ram #(
    .WIDTH (LINE_W),
    .DEPTH (DEPTH)
  ) u_dir_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sacache_scan #(
    .TAG_W (ADDR_WIDTH),
    .WAY_W (WAY_W)
  ) u_scan (
    .clk       (clk),
    .ctl       (scan_ctl),
    .ent_valid (ram_rdata[LINE_W-1]),
    .ent_tag   (ram_rdata[STAMP_W +: ADDR_WIDTH]),
    .ent_stamp (ram_rdata[STAMP_W-1:0]),
    .key_tag   (tag_q),
    .cur_way   (cmp_way),
    .sts       (scan_sts),
    .pick_way  (pick_way)
  );

  // Every line write takes a fresh stamp.
  a_stamp_step: assert property (@(posedge clk) disable iff (rst)
    (upd_go && line_wr) |=> (stamp == $past(stamp) + STAMP_W'(1)))
    else $error("stamp counter did not advance on a line write");

  // Write-back always loads the result and frees the sequencer.
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    upd_go |=> (rsp_valid && (state == ST_IDLE)))
    else $error("write-back did not load the result register");

  // A hit never counts as a miss or a memory read.
  a_hit_counts: assert property (@(posedge clk) disable iff (rst)
    (upd_go && hit_q) |=> ($stable(miss_count) && $stable(read_count)))
    else $error("hit changed the miss or read statistics");

endmodule

/* tb/set_assoc_cache_lookup_lru_fifo_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache directory testbench
// Runs a short table of directed accesses and register writes, then phases of
// random accesses under different replacement settings and idle patterns.
// Every response beat is compared field by field with a cycle-free predictor
// of the directory that keeps its own tags, stamps and access statistics.
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup_lru_fifo_core_tb import sacache_pkg::*; ();

  localparam int DIR_SETS         = 1024;
  localparam int DIR_WAYS         = 8;
  localparam int DIR_SET_BITS_MAX = 10;
  localparam int SETTLE_CYCLES    = 16;
  localparam int PHASE_ITEMS      = 48;
  localparam int CYCLE_LIMIT      = 400000;

  // Register indexes past the last register; writes to them are dropped.
  localparam logic [7:0] IDX_SPARE = 8'd4;
  localparam logic [7:0] IDX_TOP   = 8'hFF;

  typedef enum logic [0:0] { ROW_CFG, ROW_ACC } row_kind_t;
  typedef enum logic [1:0] { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  way;
    logic [31:0] reads;
    logic [31:0] writes;
    logic [31:0] hits;
    logic [31:0] misses;
  } lookup_result_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [7:0]     idx;
    logic [3:0]     data;
    logic           is_wr;
    logic [47:0]    addr;
    logic           typed;
    lookup_result_t res;
  } dir_row_t;

  typedef struct packed {
    logic       fifo;
    logic [3:0] ways;
    logic [3:0] offset;
    logic [3:0] sets;
    idle_t      idle;
  } phase_cfg_t;

  // Directed rows: results are typed in only where they are obvious.
  localparam int DIR_ROW_COUNT = 25;
  localparam dir_row_t DIR_ROWS [DIR_ROW_COUNT] = '{
    '{ROW_ACC, 8'd0, 4'd0, 1'b0, 48'h0000_0000_0000, 1'b1,
      '{1'b0, 3'd0, 32'd1, 32'd0, 32'd0, 32'd1}},
    '{ROW_ACC, 8'd0, 4'd0, 1'b1, 48'h0000_0000_003F, 1'b1,
      '{1'b1, 3'd0, 32'd1, 32'd1, 32'd1, 32'd1}},
    '{ROW_ACC, 8'd0, 4'd0, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b1,
      '{1'b0, 3'd0, 32'd2, 32'd1, 32'd1, 32'd2}},
    '{ROW_CFG, REG_WAYS_IN_USE, 4'd0, 1'b0, 48'h0, 1'b0, '0},
    '{ROW_ACC, 8'd0, 4'd0, 1'b0, 48'h0000_0000_0000, 1'b1,
      '{1'b0, 3'd0, 32'd3, 32'd1, 32'd1, 32'd3}},
    '{ROW_CFG, REG_WAYS_IN_USE, 4'd15, 1'b0, 48'h0, 1'b0, '0},
    '{ROW_ACC, 8'd0, 4'd0, 1'b1, 48'h0000_0000_0040, 1'b1,
      '{1'b0, 3'd1, 32'd4, 32'd2, 32'd1, 32'd4}},
    '{ROW_ACC, 8'd0, 4'd0, 1'b0, 48'h0000_0000_0000, 1'b1,
      '{1'b1, 3'd0, 32'd4, 32'd2, 32'd2, 32'd4}},
    '{ROW_ACC, 8'd0, 4'd0, 1'b1, 48'h0000_0000_007F, 1'b1,
      '{1'b1, 3'd1, 32'd4, 32'd3, 32'd3, 32'd4}},
    '{ROW_CFG, REG_SET_BITS, 4'd15, 1'b0, 48'h0, 1'b0, '0},
    '{ROW_CFG, REG_OFFSET_BITS, 4'd15, 1'b0, 48'h0, 1'b0, '0},
    '{ROW_ACC, 8'd0, 4'd0, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, '0},
    '{ROW_ACC, 8'd0, 4'd0, 1'b1, 48'h8000_0000_0000, 1'b0, '0},
    '{ROW_ACC, 8'd0, 4'd0, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, '0},
    '{ROW_CFG, REG_FIFO_POLICY, 4'hF, 1'b0, 48'h0, 1'b0, '0},
    '{ROW_CFG, IDX_SPARE, 4'h7, 1'b0, 48'h0, 1'b0, '0},
    '{ROW_CFG, IDX_TOP, 4'h3, 1'b0, 48'h0, 1'b0, '0},
    '{ROW_CFG, REG_OFFSET_BITS, 4'd0, 1'b0, 48'h0, 1'b0, '0},
    '{ROW_CFG, REG_SET_BITS, 4'd0, 1'b0, 48'h0, 1'b0, '0},
    '{ROW_CFG, REG_WAYS_IN_USE, 4'd2, 1'b0, 48'h0, 1'b0, '0},
    '{ROW_ACC, 8'd0, 4'd0, 1'b0, 48'h0000_0000_0000, 1'b0, '0},
    '{ROW_ACC, 8'd0, 4'd0, 1'b0, 48'h0000_0000_0005, 1'b0, '0},
    '{ROW_ACC, 8'd0, 4'd0, 1'b1, 48'h0000_0000_0006, 1'b0, '0},
    '{ROW_ACC, 8'd0, 4'd0, 1'b0, 48'h0000_0000_0000, 1'b0, '0},
    '{ROW_ACC, 8'd0, 4'd0, 1'b1, 48'h0000_0000_0005, 1'b0, '0}
  };

  // Random phases: replacement settings, geometry and idle pattern.
  localparam int PHASE_COUNT = 8;
  localparam phase_cfg_t PHASES [PHASE_COUNT] = '{
    '{1'b0, 4'd2,  4'd0,  4'd0,  IDLE_NONE},
    '{1'b1, 4'd8,  4'd4,  4'd2,  IDLE_SEND},
    '{1'b0, 4'd8,  4'd12, 4'd10, IDLE_RECV},
    '{1'b1, 4'd4,  4'd15, 4'd11, IDLE_BOTH},
    '{1'b0, 4'd9,  4'd6,  4'd3,  IDLE_NONE},
    '{1'b0, 4'd1,  4'd3,  4'd1,  IDLE_SEND},
    '{1'b1, 4'd3,  4'd0,  4'd15, IDLE_RECV},
    '{1'b0, 4'd0,  4'd1,  4'd2,  IDLE_BOTH}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        mode = 1'b0;
  logic [47:0] address = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic        hit;
  logic [2:0]  way;
  logic [31:0] read_count;
  logic [31:0] write_count;
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  // Predictor state: directory contents, age clock, statistics, registers.
  logic        dir_valid [DIR_SETS*DIR_WAYS];
  logic [47:0] dir_tag   [DIR_SETS*DIR_WAYS];
  logic [63:0] dir_stamp [DIR_SETS*DIR_WAYS];
  logic [63:0] age_clock = 64'd1;
  logic [31:0] reads_so_far = '0;
  logic [31:0] writes_so_far = '0;
  logic [31:0] hits_so_far = '0;
  logic [31:0] misses_so_far = '0;
  logic        fifo_reg = 1'b0;
  logic [3:0]  ways_reg = 4'd1;
  logic [3:0]  offset_reg = 4'd6;
  logic [3:0]  sets_reg = 4'd0;

  lookup_result_t pending_lookups [$];
  int unsigned    err_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    send_gap_pct = 0;
  int unsigned    recv_stall_pct = 0;

  set_assoc_cache_lookup_lru_fifo_core u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .mode        (mode),
    .address     (address),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .hit         (hit),
    .way         (way),
    .read_count  (read_count),
    .write_count (write_count),
    .hit_count   (hit_count),
    .miss_count  (miss_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Free-running clock.
  initial begin
    forever #4 clk = ~clk;
  end

  // The directory starts out empty.
  initial begin
    for (int e = 0; e < DIR_SETS*DIR_WAYS; e++) begin
      dir_valid[e] = 1'b0;
      dir_tag[e]   = '0;
      dir_stamp[e] = '0;
    end
  end

  function automatic int unsigned active_ways();
    if (ways_reg == 4'd0) return 1;
    if (ways_reg > DIR_WAYS) return DIR_WAYS;
    return ways_reg;
  endfunction

  function automatic int unsigned active_set_bits();
    return (sets_reg > DIR_SET_BITS_MAX) ? DIR_SET_BITS_MAX : sets_reg;
  endfunction

  function automatic logic [31:0] count_up(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // Looks up one access in the predicted directory and updates it.
  function automatic lookup_result_t predict_access(input logic is_wr, input logic [47:0] addr);
    int unsigned    nw;
    int unsigned    sb;
    int unsigned    base;
    int unsigned    pick;
    logic [63:0]    set_idx;
    logic [63:0]    tag;
    logic [63:0]    oldest;
    logic           found;
    logic           done;
    lookup_result_t r;
    nw      = active_ways();
    sb      = active_set_bits();
    set_idx = ({16'd0, addr} >> offset_reg) & ((64'd1 << sb) - 64'd1);
    tag     = {16'd0, addr} >> (offset_reg + sb);
    base    = set_idx[9:0] * DIR_WAYS;
    found   = 1'b0;
    done    = 1'b0;
    pick    = 0;
    // Search from way 0; the first empty or matching way decides.
    for (int unsigned w = 0; w < nw && !done; w++) begin
      if (!dir_valid[base+w]) begin
        dir_valid[base+w] = 1'b1;
        dir_tag[base+w]   = tag[47:0];
        dir_stamp[base+w] = age_clock;
        age_clock         = age_clock + 64'd1;
        pick = w;
        done = 1'b1;
      end else if (dir_tag[base+w] == tag[47:0]) begin
        if (!fifo_reg) begin
          dir_stamp[base+w] = age_clock;
          age_clock         = age_clock + 64'd1;
        end
        pick  = w;
        found = 1'b1;
        done  = 1'b1;
      end
    end
    // Full set with no match: evict the oldest stamp, lowest way on a tie.
    if (!done) begin
      oldest = dir_stamp[base];
      pick   = 0;
      for (int unsigned w = 1; w < nw; w++) begin
        if (dir_stamp[base+w] < oldest) begin
          oldest = dir_stamp[base+w];
          pick   = w;
        end
      end
      dir_tag[base+pick]   = tag[47:0];
      dir_valid[base+pick] = 1'b1;
      dir_stamp[base+pick] = age_clock;
      age_clock            = age_clock + 64'd1;
    end
    if (found) begin
      hits_so_far = count_up(hits_so_far);
    end else begin
      misses_so_far = count_up(misses_so_far);
      reads_so_far  = count_up(reads_so_far);
    end
    if (is_wr) begin
      writes_so_far = count_up(writes_so_far);
    end
    r.hit    = found;
    r.way    = pick[2:0];
    r.reads  = reads_so_far;
    r.writes = writes_so_far;
    r.hits   = hits_so_far;
    r.misses = misses_so_far;
    return r;
  endfunction

  // Builds an address that mostly lands on a few sets and a small tag pool,
  // so that hits, fills and evictions all occur; the rest is pure noise.
  function automatic logic [47:0] make_address(input logic [63:0] tag_base);
    logic [63:0] a;
    logic [63:0] set_sel;
    int unsigned sb;
    sb = active_set_bits();
    if ($urandom_range(99) < 12) begin
      a = {$urandom, $urandom};
    end else begin
      set_sel = ($urandom_range(99) < 80) ? 64'($urandom_range(3)) : 64'($urandom);
      set_sel = set_sel & ((64'd1 << sb) - 64'd1);
      a = (tag_base + 64'($urandom_range(active_ways() + 2))) << (offset_reg + sb);
      a = a | (set_sel << offset_reg);
      a = a | ({$urandom, $urandom} & ((64'd1 << offset_reg) - 64'd1));
    end
    return a[47:0];
  endfunction

  // Presents one access beat and records its expected result once accepted.
  task automatic put_access(input logic is_wr, input logic [47:0] addr, input logic typed,
                            input lookup_result_t typed_res);
    lookup_result_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    mode      <= is_wr;
    address   <= addr;
    do @(posedge clk); while (req_stall);
    r = predict_access(is_wr, addr);
    pending_lookups.push_back(typed ? typed_res : r);
  endtask

  // Writes one register and mirrors it in the predictor.
  task automatic write_reg(input logic [7:0] idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FIFO_POLICY: fifo_reg   = val[0];
      REG_WAYS_IN_USE: ways_reg   = val;
      REG_OFFSET_BITS: offset_reg = val;
      REG_SET_BITS:    sets_reg   = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stops sending, waits for every outstanding result, then lets the
  // write-back of the last access settle.
  task automatic drain_lookups();
    req_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Response checker: compares each taken beat with the oldest expectation.
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_lookups.size() == 0) begin
        $error("response beat with no access outstanding");
        err_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          err_count++;
        end
        if (way !== want.way) begin
          $error("way: expected %0d, got %0d", want.way, way);
          err_count++;
        end
        if (read_count !== want.reads) begin
          $error("read_count: expected %0d, got %0d", want.reads, read_count);
          err_count++;
        end
        if (write_count !== want.writes) begin
          $error("write_count: expected %0d, got %0d", want.writes, write_count);
          err_count++;
        end
        if (hit_count !== want.hits) begin
          $error("hit_count: expected %0d, got %0d", want.hits, hit_count);
          err_count++;
        end
        if (miss_count !== want.misses) begin
          $error("miss_count: expected %0d, got %0d", want.misses, miss_count);
          err_count++;
        end
      end
    end
  end

  // Watchdog covering the clearing pass and the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("set_assoc_cache_lookup_lru_fifo_core_tb: errors");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, verdict.
  initial begin
    logic [63:0] tag_base;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROW_COUNT; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        drain_lookups();
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
      end else begin
        put_access(DIR_ROWS[i].is_wr, DIR_ROWS[i].addr, DIR_ROWS[i].typed, DIR_ROWS[i].res);
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_lookups();
      write_reg(REG_FIFO_POLICY, {3'($urandom_range(7)), PHASES[p].fifo});
      write_reg(REG_WAYS_IN_USE, PHASES[p].ways);
      write_reg(REG_OFFSET_BITS, PHASES[p].offset);
      write_reg(REG_SET_BITS, PHASES[p].sets);
      case (PHASES[p].idle)
        IDLE_SEND: begin
          send_gap_pct   = 63;
          recv_stall_pct = 0;
        end
        IDLE_RECV: begin
          send_gap_pct   = 0;
          recv_stall_pct = 63;
        end
        IDLE_BOTH: begin
          send_gap_pct   = 18;
          recv_stall_pct = 18;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      // Tags of this phase cluster around one base so that sets fill up.
      tag_base = ($urandom_range(1) == 0) ? 64'd0 : ({$urandom, $urandom} >> $urandom_range(63));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        put_access(1'($urandom_range(1)), make_address(tag_base), 1'b0, '0);
      end
    end

    drain_lookups();
    if (err_count == 0) begin
      $display("set_assoc_cache_lookup_lru_fifo_core_tb: clean");
    end else begin
      $display("set_assoc_cache_lookup_lru_fifo_core_tb: errors");
    end
    $finish;
  end

endmodule
